// File: hdl/srfc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srfc_pkg
// Types, constants and helpers shared by the reply frame checker modules.
// ---------------------------------------------------------------------------
package srfc_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [10:0] READY_MASK  = 11'h7FF;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;

   localparam logic [3:0]  LAST_POS    = 4'd8;

   localparam logic [1:0]  PHASE_HIGH  = 2'd0;
   localparam logic [1:0]  PHASE_LOW   = 2'd1;
   localparam logic [1:0]  PHASE_CRC   = 2'd2;

   localparam logic        KIND_STATUS = 1'b0;
   localparam logic        KIND_MEAS   = 1'b1;

   localparam logic [1:0]  WORD_FIRST  = 2'd0;
   localparam logic [1:0]  WORD_LAST   = 2'd2;

   // one completed reply handed from the front end to the back end
   typedef struct packed {
      logic        kind;
      logic        failed;
      logic [1:0]  bad_word;
      logic [15:0] word0;
      logic [15:0] word1;
      logic [15:0] word2;
   } job_type;

   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [1:0] pos_phase(input logic [3:0] pos);
      logic [1:0] p;
      case (pos)
         4'd0, 4'd3, 4'd6: p = PHASE_HIGH;
         4'd1, 4'd4, 4'd7: p = PHASE_LOW;
         4'd2, 4'd5, 4'd8: p = PHASE_CRC;
         default:          p = PHASE_HIGH;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] pos_word(input logic [3:0] pos);
      logic [1:0] w;
      case (pos)
         4'd0, 4'd1, 4'd2: w = 2'd0;
         4'd3, 4'd4, 4'd5: w = 2'd1;
         4'd6, 4'd7, 4'd8: w = 2'd2;
         default:          w = 2'd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: hdl/sensor_reply_frame_checker_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sensor_reply_frame_checker_top
// Checks CRC-8 protected sensor replies and converts measurement words.
// ---------------------------------------------------------------------------
// One reply byte is taken per cycle while full is low. The front end frames
// words, runs the CRC-8 (poly 0x31, init 0xFF) one byte a cycle and, on the
// last byte of a reply, writes a job into a JOB_DEPTH entry queue. The back
// end takes one job per cycle unless a full output queue stalls it, and
// multiplies the temperature and humidity words in a registered product
// stage; the result goes into a two-entry output queue, clearing empty.
// full rises only while the job queue holds JOB_DEPTH unclaimed replies,
// which happens when pop is held low long enough to fill both queues.
// ---------------------------------------------------------------------------
module sensor_reply_frame_checker_top
   import srfc_pkg::*;
#(
   parameter int JOB_DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic          req_type,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          req_frame_start,
   output logic               empty,
   input  wire logic          pop,
   output logic               rsp_result_status,
   output logic [1:0]         rsp_bad_word,
   output logic               rsp_sample_ready,
   output logic [15:0]        rsp_co2_ppm,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic               rsp_reply_kind
);

   logic    req_accept;
   logic    job_push;
   job_type job_wr;
   logic    job_full;
   logic    job_valid;
   job_type job_rd;
   logic    job_take;

   assign full       = job_full;
   assign req_accept = push && !job_full;

   srfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .job_push        (job_push),
      .job_data        (job_wr)
   );

   srfc_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (job_push),
      .wr_data   (job_wr),
      .full      (job_full),
      .rd_en     (job_take),
      .not_empty (job_valid),
      .rd_data   (job_rd)
   );

   srfc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_valid             (job_valid),
      .job_data              (job_rd),
      .job_take              (job_take),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_result_status     (rsp_result_status),
      .rsp_bad_word          (rsp_bad_word),
      .rsp_sample_ready      (rsp_sample_ready),
      .rsp_co2_ppm           (rsp_co2_ppm),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_reply_kind        (rsp_reply_kind)
   );

endmodule
`default_nettype wire

// File: hdl/srfc_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srfc_front
// Frames reply bytes into words, runs the CRC and emits one job per reply.
// ---------------------------------------------------------------------------
module srfc_front
   import srfc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_accept,
   input  wire logic          req_type,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          req_frame_start,
   output logic               job_push,
   output job_type            job_data
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] word_ff [3];
   logic [1:0]  first_ff, first_in;
   logic        failed_ff, failed_in;
   logic        kind_ff, kind_in;

   logic        restart;
   logic [3:0]  pos_eff;
   logic [1:0]  phase;
   logic [1:0]  word;
   logic        failed_base;
   logic [1:0]  first_base;
   logic        mismatch;
   logic        last_word;

   always_comb begin
      restart     = req_frame_start || (pos_ff == 4'd0);
      pos_eff     = (restart || pos_ff > LAST_POS) ? 4'd0 : pos_ff;
      phase       = pos_phase(pos_eff);
      word        = pos_word(pos_eff);
      kind_in     = restart ? req_type : kind_ff;
      failed_base = restart ? 1'b0 : failed_ff;
      first_base  = restart ? WORD_FIRST : first_ff;
      mismatch    = (crc_ff != req_rx_byte);
      last_word   = (word == ((kind_in == KIND_MEAS) ? WORD_LAST : WORD_FIRST));

      pos_in    = pos_eff + 4'd1;
      crc_in    = crc_ff;
      hold_in   = hold_ff;
      failed_in = failed_base;
      first_in  = first_base;
      job_push  = 1'b0;

      case (phase)
         PHASE_HIGH: begin
            crc_in  = crc8_feed(CRC_INIT, req_rx_byte);
            hold_in = req_rx_byte;
         end
         PHASE_LOW: begin
            crc_in = crc8_feed(crc_ff, req_rx_byte);
         end
         PHASE_CRC: begin
            crc_in    = CRC_INIT;
            failed_in = failed_base | mismatch;
            if (mismatch && !failed_base) begin
               first_in = word;
            end
            if (last_word) begin
               pos_in   = 4'd0;
               job_push = req_accept;
            end
         end
         default: begin
            crc_in = CRC_INIT;
         end
      endcase

      job_data.kind     = kind_in;
      job_data.failed   = failed_in;
      job_data.bad_word = first_in;
      job_data.word0    = word_ff[0];
      job_data.word1    = word_ff[1];
      job_data.word2    = word_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         crc_ff    <= CRC_INIT;
         hold_ff   <= 8'd0;
         first_ff  <= WORD_FIRST;
         failed_ff <= 1'b0;
         kind_ff   <= KIND_STATUS;
      end else if (req_accept) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         hold_ff   <= hold_in;
         first_ff  <= first_in;
         failed_ff <= failed_in;
         kind_ff   <= kind_in;
      end
   end

   // word storage needs no reset: each word is written before the reply reads it
   always_ff @(posedge clock) begin
      if (req_accept && phase == PHASE_LOW) begin
         word_ff[word] <= {hold_ff, req_rx_byte};
      end
   end

endmodule
`default_nettype wire

// File: hdl/srfc_job_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srfc_job_queue
// Short queue of completed replies between the front end and the back end.
// ---------------------------------------------------------------------------
module srfc_job_queue
   import srfc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_data,
   output logic         full,
   input  wire logic    rd_en,
   output logic         not_empty,
   output job_type      rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   always_comb begin
      full      = (count_ff == CNT_FULL);
      not_empty = (count_ff != '0);
      rd_data   = mem_ff[rd_ptr_ff];
      do_wr     = wr_en && !full;
      do_rd     = rd_en && not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/srfc_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srfc_back
// Scales a completed reply into readings and holds results for the consumer.
// ---------------------------------------------------------------------------
module srfc_back
   import srfc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           job_valid,
   input  wire job_type        job_data,
   output logic                job_take,
   output logic                empty,
   input  wire logic           pop,
   output logic                rsp_result_status,
   output logic [1:0]          rsp_bad_word,
   output logic                rsp_sample_ready,
   output logic [15:0]         rsp_co2_ppm,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [13:0]         rsp_humidity_centi,
   output logic                rsp_reply_kind
);

   typedef struct packed {
      logic               status;
      logic [1:0]         bad_word;
      logic               sample_ready;
      logic [15:0]        co2;
      logic signed [14:0] temp;
      logic [13:0]        hum;
      logic               kind;
   } rsp_type;

   // product stage
   logic        stage_valid_ff, stage_valid_in;
   logic        stage_kind_ff;
   logic        stage_failed_ff;
   logic [1:0]  stage_bad_ff;
   logic        stage_ready_ff;
   logic [15:0] stage_co2_ff;
   logic [30:0] stage_tprod_ff;
   logic [29:0] stage_hprod_ff;

   // result queue
   rsp_type     out_ff [2];
   logic        out_wr_ptr_ff, out_wr_ptr_in;
   logic        out_rd_ptr_ff, out_rd_ptr_in;
   logic [1:0]  out_count_ff, out_count_in;

   logic        out_full;
   logic        stage_move;
   logic        do_pop;
   logic        measure_ok;
   rsp_type     result;
   logic [14:0] temp_raw;

   always_comb begin
      out_full   = (out_count_ff == 2'd2);
      stage_move = stage_valid_ff && !out_full;
      job_take   = job_valid && (!stage_valid_ff || stage_move);
      empty      = (out_count_ff == 2'd0);
      do_pop     = pop && !empty;

      stage_valid_in = job_take || (stage_valid_ff && !stage_move);

      measure_ok = !stage_failed_ff && (stage_kind_ff == KIND_MEAS);
      temp_raw   = stage_tprod_ff[30:16] - TEMP_OFFSET;

      result.status       = stage_failed_ff;
      result.bad_word     = stage_bad_ff;
      result.sample_ready = stage_ready_ff;
      result.co2          = measure_ok ? stage_co2_ff : 16'd0;
      result.temp         = measure_ok ? signed'(temp_raw) : 15'sd0;
      result.hum          = measure_ok ? stage_hprod_ff[29:16] : 14'd0;
      result.kind         = stage_kind_ff;

      out_wr_ptr_in = stage_move ? !out_wr_ptr_ff : out_wr_ptr_ff;
      out_rd_ptr_in = do_pop ? !out_rd_ptr_ff : out_rd_ptr_ff;
      out_count_in  = out_count_ff;
      if (stage_move && !do_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (do_pop && !stage_move) begin
         out_count_in = out_count_ff - 2'd1;
      end

      rsp_result_status     = out_ff[out_rd_ptr_ff].status;
      rsp_bad_word          = out_ff[out_rd_ptr_ff].bad_word;
      rsp_sample_ready      = out_ff[out_rd_ptr_ff].sample_ready;
      rsp_co2_ppm           = out_ff[out_rd_ptr_ff].co2;
      rsp_temperature_centi = out_ff[out_rd_ptr_ff].temp;
      rsp_humidity_centi    = out_ff[out_rd_ptr_ff].hum;
      rsp_reply_kind        = out_ff[out_rd_ptr_ff].kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_wr_ptr_ff  <= 1'b0;
         out_rd_ptr_ff  <= 1'b0;
         out_count_ff   <= 2'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_wr_ptr_ff  <= out_wr_ptr_in;
         out_rd_ptr_ff  <= out_rd_ptr_in;
         out_count_ff   <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         stage_kind_ff   <= job_data.kind;
         stage_failed_ff <= job_data.failed;
         stage_bad_ff    <= job_data.bad_word;
         stage_ready_ff  <= !job_data.failed && (job_data.kind == KIND_STATUS)
                            && ((job_data.word0[10:0] & READY_MASK) != 11'd0);
         stage_co2_ff    <= job_data.word0;
         stage_tprod_ff  <= 31'(job_data.word1) * 31'(TEMP_SCALE);
         stage_hprod_ff  <= 30'(job_data.word2) * 30'(HUM_SCALE);
      end
      if (stage_move) begin
         out_ff[out_wr_ptr_ff] <= result;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff != 2'd3)
      else $error("result queue count out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && out_full && !do_pop |=> stage_valid_ff && $stable(stage_tprod_ff))
      else $error("stalled stage lost its reply");

   a_meas_not_ready: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_reply_kind == KIND_MEAS) |-> !rsp_sample_ready)
      else $error("measurement result flagged sample ready");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_result_status |->
         rsp_co2_ppm == 16'd0 && rsp_temperature_centi == 15'sd0
         && rsp_humidity_centi == 14'd0 && !rsp_sample_ready)
      else $error("failed reply carries readings");

endmodule
`default_nettype wire

// File: sim/sensor_reply_frame_checker_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_reply_frame_checker_top_tb
// Self-checking bench for the sensor reply CRC checker and unit converter.
// ---------------------------------------------------------------------------
// Reply bytes are pushed one request at a time. Each accepted byte goes into
// a reply predictor that frames words, runs the CRC-8 and builds the expected
// result when a reply completes. Popped results are compared field by field
// against the oldest prediction. The stimulus opens with hand-picked replies
// and continues with random replies, broken replies and noise bytes under
// three idle patterns, one long receiver hold-off and sender drain pauses.
// ---------------------------------------------------------------------------
module sensor_reply_frame_checker_top_tb
   import srfc_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BYTES_PER_PHASE = 400;

   typedef struct {
      logic               status;
      logic [1:0]         bad_word;
      logic               ready;
      logic [15:0]        co2;
      logic signed [14:0] temp;
      logic [13:0]        hum;
      logic               kind;
   } reply_type;

   class reply_scoreboard;
      logic [3:0]  pos;
      logic [7:0]  crc;
      logic [7:0]  high_byte;
      logic [15:0] words [3];
      logic        failed;
      logic [1:0]  first_bad;
      logic        kind;
      reply_type   expected_replies [$];
      int          mismatches;

      function new();
         pos = '0;
         crc = CRC_INIT;
         high_byte = '0;
         failed = 1'b0;
         first_bad = '0;
         kind = KIND_STATUS;
         mismatches = 0;
      endfunction

      static function logic [7:0] crc8_step(logic [7:0] c, logic [7:0] data);
         logic [7:0] r;
         logic       fb;
         r = c;
         for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // advance the framing by one accepted request
      function void note_byte(logic kind_in, logic [7:0] data, logic start);
         logic [1:0]  phase;
         logic [1:0]  word;
         logic [31:0] t;
         logic [31:0] h;
         reply_type   r;
         if (start || pos == 4'd0) begin
            pos = 4'd0;
            crc = CRC_INIT;
            failed = 1'b0;
            first_bad = WORD_FIRST;
            kind = kind_in;
         end
         if (pos > LAST_POS) pos = 4'd0;
         phase = 2'(pos % 4'd3);
         word = 2'(pos / 4'd3);
         if (phase == PHASE_HIGH) begin
            crc = crc8_step(CRC_INIT, data);
            high_byte = data;
            pos++;
            return;
         end
         if (phase == PHASE_LOW) begin
            crc = crc8_step(crc, data);
            words[word] = {high_byte, data};
            pos++;
            return;
         end
         if (crc != data && !failed) begin
            failed = 1'b1;
            first_bad = word;
         end
         crc = CRC_INIT;
         if (word != ((kind == KIND_MEAS) ? WORD_LAST : WORD_FIRST)) begin
            pos++;
            return;
         end
         pos = 4'd0;
         r.status = failed;
         r.bad_word = first_bad;
         r.ready = 1'b0;
         r.co2 = '0;
         r.temp = '0;
         r.hum = '0;
         r.kind = kind;
         if (!failed) begin
            if (kind == KIND_STATUS) begin
               r.ready = |(words[0][10:0] & READY_MASK);
            end else begin
               t = (32'(TEMP_SCALE) * 32'(words[1])) >> 16;
               h = (32'(HUM_SCALE) * 32'(words[2])) >> 16;
               r.co2 = words[0];
               r.temp = 15'(t - 32'(TEMP_OFFSET));
               r.hum = 14'(h);
            end
         end
         expected_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type e;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: status=%0d bad_word=%0d kind=%0d",
                        got.status, got.bad_word, got.kind);
            return;
         end
         e = expected_replies.pop_front();
         if (got.status !== e.status || got.bad_word !== e.bad_word ||
             got.ready !== e.ready || got.co2 !== e.co2 || got.temp !== e.temp ||
             got.hum !== e.hum || got.kind !== e.kind) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply mismatch: expected status=%0d bad_word=%0d ready=%0d co2=%0d",
                        e.status, e.bad_word, e.ready, e.co2);
               $display("                expected temp=%0d hum=%0d kind=%0d",
                        e.temp, e.hum, e.kind);
               $display("                actual   status=%0d bad_word=%0d ready=%0d co2=%0d",
                        got.status, got.bad_word, got.ready, got.co2);
               $display("                actual   temp=%0d hum=%0d kind=%0d",
                        got.temp, got.hum, got.kind);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic               req_type;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               empty;
   logic               pop;
   logic               rsp_result_status;
   logic [1:0]         rsp_bad_word;
   logic               rsp_sample_ready;
   logic [15:0]        rsp_co2_ppm;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic               rsp_reply_kind;

   reply_scoreboard sb = new();
   int send_idle_pct = 10;
   int recv_idle_pct = 49;
   int hold_off_cycles = 0;
   int bytes_sent = 0;
   int quiet_cycles = 0;

   sensor_reply_frame_checker_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_type              (req_type),
      .req_rx_byte           (req_rx_byte),
      .req_frame_start       (req_frame_start),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_result_status     (rsp_result_status),
      .rsp_bad_word          (rsp_bad_word),
      .rsp_sample_ready      (rsp_sample_ready),
      .rsp_co2_ppm           (rsp_co2_ppm),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_reply_kind        (rsp_reply_kind)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side
   initial begin
      reply_type got;
      pop = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            pop <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         @(posedge clock);
         if (pop && !empty) begin
            got.status = rsp_result_status;
            got.bad_word = rsp_bad_word;
            got.ready = rsp_sample_ready;
            got.co2 = rsp_co2_ppm;
            got.temp = rsp_temperature_centi;
            got.hum = rsp_humidity_centi;
            got.kind = rsp_reply_kind;
            sb.check_reply(got);
         end
      end
   end

   task automatic push_byte(input logic kind, input logic [7:0] data, input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_type <= kind;
      req_rx_byte <= data;
      req_frame_start <= start;
      do @(posedge clock); while (full);
      sb.note_byte(kind, data, start);
      bytes_sent++;
   endtask

   // hold the sender until every predicted reply has been popped
   task automatic drain_replies();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_reply(input logic kind, input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [2:0] corrupt,
                             input logic start);
      logic [15:0] words [3];
      logic [7:0]  c;
      int          n;
      words[0] = w0;
      words[1] = w1;
      words[2] = w2;
      n = (kind == KIND_MEAS) ? 3 : 1;
      for (int w = 0; w < n; w++) begin
         c = reply_scoreboard::crc8_step(reply_scoreboard::crc8_step(CRC_INIT,
                                         words[w][15:8]), words[w][7:0]);
         if (corrupt[w]) c ^= 8'($urandom_range(1, 255));
         // kind is only sampled on the first byte; toggle it elsewhere
         push_byte((w == 0) ? kind : 1'($urandom_range(0, 1)), words[w][15:8],
                   (w == 0) ? start : 1'b0);
         push_byte(1'($urandom_range(0, 1)), words[w][7:0], 1'b0);
         push_byte(1'($urandom_range(0, 1)), c, 1'b0);
      end
   endtask

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      logic        kind;
      logic [15:0] w0;
      logic [2:0]  corrupt;
      int          limit;
      int          len;
      reset = 1'b1;
      push = 1'b0;
      req_type = KIND_STATUS;
      req_rx_byte = '0;
      req_frame_start = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ready status, status with low bits clear and no start flag, bad CRC
      send_reply(KIND_STATUS, 16'h0001, 16'h0000, 16'h0000, 3'b000, 1'b1);
      send_reply(KIND_STATUS, 16'hF800, 16'h0000, 16'h0000, 3'b000, 1'b0);
      send_reply(KIND_STATUS, 16'hFFFF, 16'h0000, 16'h0000, 3'b001, 1'b1);
      // measurement extremes, then failures in the last two words
      send_reply(KIND_MEAS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1'b1);
      send_reply(KIND_MEAS, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1);
      send_reply(KIND_MEAS, 16'h1234, 16'h6666, 16'h8000, 3'b110, 1'b1);
      // drop a partial measurement reply by restarting mid-frame
      push_byte(KIND_MEAS, 8'hA5, 1'b1);
      push_byte(KIND_STATUS, 8'h5A, 1'b0);
      push_byte(KIND_MEAS, 8'h3C, 1'b0);
      send_reply(KIND_STATUS, 16'h07FF, 16'h0000, 16'h0000, 3'b000, 1'b1);
      drain_replies();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 49 : 0;
         recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 10 : 0;
         // receiver holds off while the sender keeps offering bytes
         if (ph == 0) hold_off_cycles = 120;
         limit = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < limit) begin
            if ($urandom_range(0, 99) < 85) begin
               kind = 1'($urandom_range(0, 1));
               w0 = pick_word();
               if (kind == KIND_STATUS && $urandom_range(0, 3) == 0) w0 &= 16'hF800;
               corrupt[0] = ($urandom_range(0, 9) == 0);
               corrupt[1] = ($urandom_range(0, 9) == 0);
               corrupt[2] = ($urandom_range(0, 9) == 0);
               send_reply(kind, w0, pick_word(), pick_word(), corrupt,
                          1'($urandom_range(0, 3) != 0));
            end else begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            (i == 0) ? 1'b1 : 1'($urandom_range(0, 7) == 0));
            end
         end
         drain_replies();
      end

      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/srfc_pkg.sv
hdl/srfc_front.sv
hdl/srfc_job_queue.sv
hdl/srfc_back.sv
hdl/sensor_reply_frame_checker_top.sv
sim/sensor_reply_frame_checker_top_tb.sv
